[src/meter_pulse_qualifier_defines.svh]
// Assertion macros shared by the meter pulse qualifier RTL.
`ifndef METER_PULSE_QUALIFIER_DEFINES_SVH
`define METER_PULSE_QUALIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("meter_pulse_qualifier: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("meter_pulse_qualifier: assertion failed");

`endif

[src/mpq_pkg.sv]
// Package with the command codes and fixed widths of the meter pulse qualifier.
`default_nettype none

package mpq_pkg;

  localparam int unsigned OutTimeWidth = 48;
  localparam int unsigned MinPulseWidth = 32;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResIdxWidth = 2;

  typedef enum logic [2:0] {
    CmdOn     = 3'd0,
    CmdOnOff  = 3'd1,
    CmdOff    = 3'd2,
    CmdCancel = 3'd3,
    CmdResume = 3'd4,
    CmdReset  = 3'd5
  } cmd_e;

endpackage

`default_nettype wire

[src/meter_pulse_qualifier.sv]
// A transaction accepted into the input register is processed once the result buffer is
// empty or hands out its last result; its results are then registered and presented in order.
// Throughput: one input transaction per cycle when it causes at most one result and the output
// is not stalled; an item causing more results (at most three) holds the single result buffer.
// Reset (rst_ni low, asynchronous) empties the edge buffer, sets the on-unreported flag,
// clears the gap limit to zero and drops any pending input or result transactions.
`default_nettype none
`include "meter_pulse_qualifier_defines.svh"

module meter_pulse_qualifier #(
  parameter int unsigned TIME_WIDTH = 48
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration: minimum valid on or off phase in microseconds.
  input  wire logic                               cfg_we_i,
  input  wire logic [mpq_pkg::MinPulseWidth-1:0]  cfg_wdata_i,
  // Input channel.
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               is_reset_i,
  input  wire logic [TIME_WIDTH-1:0]              event_time_i,
  input  wire logic                               level_on_i,
  // Output channel.
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [2:0]                              command_o,
  output logic [mpq_pkg::OutTimeWidth-1:0]        on_time_o,
  output logic [mpq_pkg::OutTimeWidth-1:0]        off_time_o,
  output logic                                    last_o
);

  localparam int unsigned Ow = mpq_pkg::OutTimeWidth;
  localparam int unsigned Nr = mpq_pkg::MaxResults;
  localparam int unsigned Iw = mpq_pkg::ResIdxWidth;

  // Configuration register.
  logic [mpq_pkg::MinPulseWidth-1:0] gap_limit_q;

  // Input register stage.
  logic                  in_valid_q;
  logic                  in_rst_q;
  logic [TIME_WIDTH-1:0] in_time_q;
  logic                  in_on_q;

  // Edge buffer. Slot 0 holds the on edge and slot 1 the off edge. The third
  // slot of the on/off/on order is the incoming edge itself and is resolved
  // in the same cycle, so it is never stored.
  logic [1:0]            fill_q, fill_d;
  logic                  unrep_q, unrep_d;
  logic [TIME_WIDTH-1:0] e0_q, e0_d;
  logic [TIME_WIDTH-1:0] e1_q, e1_d;

  // Result buffer: up to three results of one transaction, read out in order.
  mpq_pkg::cmd_e   res_cmd_q [Nr];
  logic [Ow-1:0]   res_on_q  [Nr];
  logic [Ow-1:0]   res_off_q [Nr];
  logic [Iw-1:0]   res_cnt_q;
  logic [Iw-1:0]   res_rd_q;

  mpq_pkg::cmd_e   res_cmd_d [Nr];
  logic [Ow-1:0]   res_on_d  [Nr];
  logic [Ow-1:0]   res_off_d [Nr];
  logic [Iw-1:0]   res_n;

  logic in_accept;
  logic out_pop;
  logic out_last;
  logic out_is_reset;
  logic fire;

  // Gap tests. A gap is the modulo difference of a later and an earlier edge
  // time and is short when it falls below the configured minimum.
  logic [TIME_WIDTH-1:0] min_ext;
  logic [TIME_WIDTH-1:0] gap_01, gap_0t, gap_1t;
  logic                  short_01, short_0t, short_1t;

  assign min_ext  = TIME_WIDTH'(gap_limit_q);
  assign gap_01   = e1_q - e0_q;
  assign gap_0t   = in_time_q - e0_q;
  assign gap_1t   = in_time_q - e1_q;
  assign short_01 = gap_01 < min_ext;
  assign short_0t = gap_0t < min_ext;
  assign short_1t = gap_1t < min_ext;

  // Handshakes. The input register is freed when its transaction is processed,
  // which happens once the result buffer is empty or hands out its last result
  // in this cycle.
  assign out_valid_o = res_rd_q < res_cnt_q;
  assign out_last    = res_rd_q == (res_cnt_q - Iw'(1));
  assign out_pop     = out_valid_o && !out_stall_i;
  assign fire        = in_valid_q && (!out_valid_o || (out_pop && out_last));
  assign in_stall_o  = in_valid_q && !fire;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign command_o  = res_cmd_q[res_rd_q];
  assign on_time_o  = res_on_q[res_rd_q];
  assign off_time_o = res_off_q[res_rd_q];
  assign last_o     = out_last;

  assign out_is_reset = out_valid_o && (command_o == mpq_pkg::CmdReset);

  // Single processing pass: update the edge buffer with the registered
  // transaction and produce every result it causes, in order.
  always_comb begin
    fill_d  = fill_q;
    unrep_d = unrep_q;
    e0_d    = e0_q;
    e1_d    = e1_q;
    res_n   = '0;
    for (int i = 0; i < Nr; i++) begin
      res_cmd_d[i] = mpq_pkg::CmdOn;
      res_on_d[i]  = '0;
      res_off_d[i] = '0;
    end

    if (in_rst_q) begin
      // A meter reset reports itself and then re-examines the buffer as it
      // stands, so a buffered pair is reported a second time.
      res_cmd_d[res_n] = mpq_pkg::CmdReset;
      res_n            = res_n + Iw'(1);
      unique case (fill_q)
        2'd1: begin
          if (unrep_q) begin
            res_cmd_d[res_n] = mpq_pkg::CmdOn;
            res_on_d[res_n]  = Ow'(e0_q);
            res_n            = res_n + Iw'(1);
            unrep_d          = 1'b0;
          end
        end
        2'd2: begin
          if (short_01) begin
            res_cmd_d[res_n] = mpq_pkg::CmdCancel;
            res_on_d[res_n]  = Ow'(e0_q);
            res_n            = res_n + Iw'(1);
            fill_d           = 2'd0;
          end else begin
            res_cmd_d[res_n] = unrep_q ? mpq_pkg::CmdOnOff : mpq_pkg::CmdOff;
            res_on_d[res_n]  = Ow'(e0_q);
            res_off_d[res_n] = Ow'(e1_q);
            res_n            = res_n + Iw'(1);
          end
        end
        default: begin
        end
      endcase
    end else begin
      unique case (fill_q)
        2'd0: begin
          // A new on edge is buffered and reported at once. Off edges are dropped.
          if (in_on_q) begin
            e0_d             = in_time_q;
            fill_d           = 2'd1;
            unrep_d          = 1'b0;
            res_cmd_d[res_n] = mpq_pkg::CmdOn;
            res_on_d[res_n]  = Ow'(in_time_q);
            res_n            = res_n + Iw'(1);
          end
        end
        2'd1: begin
          if (!in_on_q) begin
            e1_d = in_time_q;
            if (short_0t) begin
              res_cmd_d[res_n] = mpq_pkg::CmdCancel;
              res_on_d[res_n]  = Ow'(e0_q);
              res_n            = res_n + Iw'(1);
              fill_d           = 2'd0;
            end else begin
              res_cmd_d[res_n] = unrep_q ? mpq_pkg::CmdOnOff : mpq_pkg::CmdOff;
              res_on_d[res_n]  = Ow'(e0_q);
              res_off_d[res_n] = Ow'(in_time_q);
              res_n            = res_n + Iw'(1);
              fill_d           = 2'd2;
            end
          end else if (unrep_q) begin
            // The second on edge is dropped; only a still unreported on is sent.
            res_cmd_d[res_n] = mpq_pkg::CmdOn;
            res_on_d[res_n]  = Ow'(e0_q);
            res_n            = res_n + Iw'(1);
            unrep_d          = 1'b0;
          end
        end
        2'd2: begin
          if (in_on_q) begin
            fill_d  = 2'd1;
            unrep_d = 1'b0;
            if (short_1t) begin
              // The off phase was too short: the pulse resumes. When the
              // first on phase was short too and never reported, it is
              // cancelled and the new on edge takes its place.
              if (unrep_q && short_01) begin
                res_cmd_d[res_n] = mpq_pkg::CmdCancel;
                res_on_d[res_n]  = Ow'(e0_q);
                res_n            = res_n + Iw'(1);
                e0_d             = in_time_q;
              end
              res_cmd_d[res_n] = mpq_pkg::CmdResume;
              res_on_d[res_n]  = Ow'(e0_d);
              res_n            = res_n + Iw'(1);
              if (unrep_q) begin
                res_cmd_d[res_n] = mpq_pkg::CmdOn;
                res_on_d[res_n]  = Ow'(e0_d);
                res_n            = res_n + Iw'(1);
              end
            end else begin
              // The pulse is complete; the new on edge opens the next one.
              if (unrep_q) begin
                if (short_01) begin
                  res_cmd_d[res_n] = mpq_pkg::CmdCancel;
                  res_on_d[res_n]  = Ow'(e0_q);
                end else begin
                  res_cmd_d[res_n] = mpq_pkg::CmdOnOff;
                  res_on_d[res_n]  = Ow'(e0_q);
                  res_off_d[res_n] = Ow'(e1_q);
                end
                res_n = res_n + Iw'(1);
              end
              e0_d             = in_time_q;
              res_cmd_d[res_n] = mpq_pkg::CmdOn;
              res_on_d[res_n]  = Ow'(in_time_q);
              res_n            = res_n + Iw'(1);
            end
          end else begin
            // An off edge after on and off clears the buffer silently.
            fill_d = 2'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_limit_q <= '0;
      in_valid_q  <= 1'b0;
      fill_q      <= 2'd0;
      unrep_q     <= 1'b1;
      res_cnt_q   <= '0;
      res_rd_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        gap_limit_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        fill_q    <= fill_d;
        unrep_q   <= unrep_d;
        res_cnt_q <= res_n;
        res_rd_q  <= '0;
      end else if (out_pop) begin
        res_rd_q <= res_rd_q + Iw'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_rst_q  <= is_reset_i;
      in_time_q <= event_time_i;
      in_on_q   <= level_on_i;
    end
    if (fire) begin
      e0_q <= e0_d;
      e1_q <= e1_d;
      for (int i = 0; i < Nr; i++) begin
        res_cmd_q[i] <= res_cmd_d[i];
        res_on_q[i]  <= res_on_d[i];
        res_off_q[i] <= res_off_d[i];
      end
    end
  end

  // Between transactions the buffer never holds more than an on/off pair.
  `MPQ_ASSERT_IMPL(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q != 2'd3)
  // A processed transaction with results shows its first one in the next cycle.
  `MPQ_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, fire && (|res_n), out_valid_o && (res_rd_q == '0))
  // A reset command is always the first result of its transaction.
  `MPQ_ASSERT_IMPL(a_reset_first, clk_i, rst_ni, out_is_reset, res_rd_q == '0)
  // The input register is only released while no earlier result is left behind.
  `MPQ_ASSERT_NEXT(a_no_overwrite, clk_i, rst_ni, out_valid_o && !out_pop, $stable(res_cnt_q))

endmodule

`default_nettype wire
